// File: rtl/assert_macros.svh
// Assertion macros used by the checker file rbpg_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RBPG_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: implication failed");

// implication after a fixed number of cycles
`define RBPG_ASSERT_DELAY(lbl, clk, rst_n, pre, n, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
    else $error("%m: delayed implication failed");

`endif

// File: rtl/rbpg_pkg.sv
// Package for the range/bearing position and geofence core.
// Holds widths, constants, tables and CORDIC helpers; no dependencies.
`timescale 1ns / 1ps

package rbpg_pkg;

  localparam int COORD_FRAC_BITS = 20;
  localparam int CORDIC_STEPS    = 24;
  localparam int ATAN_ENTRIES    = 41;

  localparam int LAT_W  = 28;
  localparam int LNG_W  = 29;
  localparam int BRG_W  = 25;
  localparam int DIST_W = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 29;

  localparam logic [CFG_IDX_W-1:0] CFG_LAT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LNG_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LNG_MAX = 2'd3;

  localparam logic signed [LAT_W-1:0] LAT_MIN_RST = 28'sd54525952;
  localparam logic signed [LAT_W-1:0] LAT_MAX_RST = 28'sd55399399;
  localparam logic signed [LNG_W-1:0] LNG_MIN_RST = -29'sd5767168;
  localparam logic signed [LNG_W-1:0] LNG_MAX_RST = -29'sd4194304;

  localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(90 << COORD_FRAC_BITS);
  localparam logic signed [LNG_W-1:0] LNG_LIM = LNG_W'(180 << COORD_FRAC_BITS);

  // CORDIC datapath
  localparam int XY_W = 33;
  localparam int Z_W  = 34;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam int TINY_COS_Q22 = 4096;

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // reciprocal constants, scaled by 2^32
  localparam int REC_W = 27;
  localparam logic [REC_W-1:0] RECIP45 = 27'd95443717;
  localparam logic [REC_W-1:0] RECIP60 = 27'd71582788;

  localparam int AB_W    = BRG_W + REC_W - 32;
  localparam int AL_W    = LAT_W + REC_W - 32;
  localparam int LT_SH   = 29 - COORD_FRAC_BITS;
  localparam int FRAC_W  = 13;
  localparam int RES45_W = 6;

  // post-CORDIC arithmetic
  localparam int CS_W    = XY_W - 8;
  localparam int PLAT_W  = DIST_W + XY_W + 1;
  localparam int PNUM_W  = DIST_W + CS_W + 1;
  localparam int LAT_SH  = 38 - COORD_FRAC_BITS;
  localparam int LNG_SH  = COORD_FRAC_BITS - 8;
  localparam int VLAT_W  = 29;
  localparam int QLAT_W  = VLAT_W + REC_W - 32;
  localparam int DEN_W   = 28;
  localparam int DIV_BITS = COORD_FRAC_BITS + 9;
  localparam int REM_W   = DEN_W + DIV_BITS;

  localparam int LATENCY = 8 + CORDIC_STEPS + DIV_BITS;

  typedef logic [FRAC_W-1:0] frac_tbl_t [45];

  // round((r * 2^sh) / 360) for the remainder after division by 45
  function automatic frac_tbl_t build_frac(int sh);
    frac_tbl_t t;
    for (int r = 0; r < 45; r++) begin
      t[r] = FRAC_W'(((r << sh) + 180) / 360);
    end
    return t;
  endfunction

  localparam frac_tbl_t BRG_FRAC = build_frac(16);
  localparam frac_tbl_t LAT_FRAC = build_frac(32 - COORD_FRAC_BITS);

  typedef struct packed {
    logic signed [LAT_W-1:0] olat;
    logic signed [LNG_W-1:0] olng;
    logic [DIST_W-1:0]       rng;
  } obs_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
  } rot_t;

  typedef struct packed {
    logic signed [LAT_W-1:0] tlat;
    logic                    lat_sat;
    logic signed [LNG_W-1:0] olng;
    logic [DEN_W-1:0]        den;
    logic                    ovf;
    logic                    tiny;
    logic                    nneg;
    logic                    nzero;
  } dside_t;

  function automatic rot_t rot_init(logic [31:0] ang);
    rot_t        r;
    logic [31:0] quad;
    logic [31:0] a;
    quad  = ang + 32'h4000_0000;
    r.neg = quad[31];
    a     = quad[31] ? ang + 32'h8000_0000 : ang;
    r.z   = Z_W'($signed(a));
    r.x   = XY_W'(CORDIC_GAIN_Q30);
    r.y   = '0;
    return r;
  endfunction

  function automatic rot_t rot_step(rot_t c, int unsigned sh);
    rot_t r;
    r = c;
    if (!c.z[Z_W-1]) begin
      r.x = c.x - (c.y >>> sh);
      r.y = c.y + (c.x >>> sh);
      r.z = c.z - Z_W'(ATAN_TURNS[sh]);
    end else begin
      r.x = c.x + (c.y >>> sh);
      r.y = c.y - (c.x >>> sh);
      r.z = c.z + Z_W'(ATAN_TURNS[sh]);
    end
    return r;
  endfunction

endpackage

// File: rtl/range_bearing_position_geofence_core.sv
// Top level of the range/bearing target position core with geofence flag.
// Depends on rbpg_pkg.
`timescale 1ns / 1ps

// Usage:
//   Present observer_lat_i, observer_lng_i, bearing_i and distance_i with
//   start_i high; the transaction is taken at that clock edge. busy_o stays
//   low, so a new transaction may start in every cycle.
//   Each transaction yields one result on target_lat_o, target_lng_o,
//   in_region_o and out_of_range_o, shown for one cycle with done_o high.
//   The pipeline stages, in order: input and angle conversion (3), one
//   CORDIC step per stage for bearing and latitude side by side, sign fix
//   (1), products (2), one quotient bit per stage of the longitude divider,
//   saturation (1) and the geofence compare (1). Throughput is one
//   transaction per cycle; results leave in the order taken.
//   Geofence bounds are written through cfg_we_i / cfg_idx_i / cfg_data_i;
//   the user must write them only while no transaction is in flight, which
//   the block does not enforce. Each of the four indexes selects a bound.
//   Reset clears all in-flight transactions and loads the default bounds.
//   The receiver cannot stall; results are never held back.
module range_bearing_position_geofence_core import rbpg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [LAT_W-1:0] observer_lat_i,
  input  logic signed [LNG_W-1:0] observer_lng_i,
  input  logic [BRG_W-1:0]        bearing_i,
  input  logic [DIST_W-1:0]       distance_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output logic                    done_o,
  output logic signed [LAT_W-1:0] target_lat_o,
  output logic signed [LNG_W-1:0] target_lng_o,
  output logic                    in_region_o,
  output logic                    out_of_range_o
);

  logic               accept;
  logic [LATENCY-1:0] vld_q;

  logic signed [LAT_W-1:0] lat_min_q, lat_max_q;
  logic signed [LNG_W-1:0] lng_min_q, lng_max_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign done_o = vld_q[LATENCY-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_min_q <= LAT_MIN_RST;
      lat_max_q <= LAT_MAX_RST;
      lng_min_q <= LNG_MIN_RST;
      lng_max_q <= LNG_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LAT_MIN: lat_min_q <= $signed(cfg_data_i[LAT_W-1:0]);
        CFG_LAT_MAX: lat_max_q <= $signed(cfg_data_i[LAT_W-1:0]);
        CFG_LNG_MIN: lng_min_q <= $signed(cfg_data_i[LNG_W-1:0]);
        CFG_LNG_MAX: lng_max_q <= $signed(cfg_data_i[LNG_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stage 1: capture
  obs_t             obs1_q;
  logic [BRG_W-1:0] brg1_q;

  always_ff @(posedge clk_i) begin
    obs1_q <= '{olat: observer_lat_i, olng: observer_lng_i, rng: distance_i};
    brg1_q <= bearing_i;
  end

  // Stage 2: reciprocal products for division by 45
  logic                     lneg1;
  logic [LAT_W-1:0]         lmag1;
  logic [BRG_W+REC_W-1:0]   prod_b;
  logic [LAT_W+REC_W-1:0]   prod_l;
  obs_t                     obs2_q;
  logic [BRG_W-1:0]         brg2_q;
  logic [LAT_W-1:0]         lmag2_q;
  logic                     lneg2_q;
  logic [AB_W-1:0]          a0b2_q;
  logic [AL_W-1:0]          a0l2_q;

  assign lneg1  = obs1_q.olat[LAT_W-1];
  assign lmag1  = lneg1 ? LAT_W'(-obs1_q.olat) : LAT_W'(obs1_q.olat);
  assign prod_b = (BRG_W+REC_W)'(brg1_q) * (BRG_W+REC_W)'(RECIP45);
  assign prod_l = (LAT_W+REC_W)'(lmag1) * (LAT_W+REC_W)'(RECIP45);

  always_ff @(posedge clk_i) begin
    obs2_q  <= obs1_q;
    brg2_q  <= brg1_q;
    lmag2_q <= lmag1;
    lneg2_q <= lneg1;
    a0b2_q  <= prod_b[BRG_W+REC_W-1:32];
    a0l2_q  <= prod_l[LAT_W+REC_W-1:32];
  end

  // Stage 3: binary angles
  logic [BRG_W-1:0]   rb_full;
  logic [LAT_W-1:0]   rl_full;
  logic [6:0]         rb0, rl0;
  logic [RES45_W-1:0] rb, rl;
  logic [AB_W-1:0]    ab;
  logic [AL_W-1:0]    al;
  logic [31:0]        bturns, lt_mag, lturns;
  obs_t               obs3_q;
  logic [31:0]        bt3_q, lt3_q;

  always_comb begin
    rb_full = brg2_q - BRG_W'(a0b2_q) * BRG_W'(45);
    rl_full = lmag2_q - LAT_W'(a0l2_q) * LAT_W'(45);
    rb0     = rb_full[6:0];
    rl0     = rl_full[6:0];
    if (rb0 >= 7'd45) begin
      ab = a0b2_q + AB_W'(1);
      rb = RES45_W'(rb0 - 7'd45);
    end else begin
      ab = a0b2_q;
      rb = RES45_W'(rb0);
    end
    if (rl0 >= 7'd45) begin
      al = a0l2_q + AL_W'(1);
      rl = RES45_W'(rl0 - 7'd45);
    end else begin
      al = a0l2_q;
      rl = RES45_W'(rl0);
    end
    bturns = (32'(ab) << 13) + 32'(BRG_FRAC[rb]);
    lt_mag = (32'(al) << LT_SH) + 32'(LAT_FRAC[rl]);
    lturns = lneg2_q ? -lt_mag : lt_mag;
  end

  always_ff @(posedge clk_i) begin
    obs3_q <= obs2_q;
    bt3_q  <= bturns;
    lt3_q  <= lturns;
  end

  // CORDIC: one step per stage, bearing and latitude in parallel
  rot_t brot_q [CORDIC_STEPS];
  rot_t lrot_q [CORDIC_STEPS];
  obs_t cobs_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rot_t bin, lin;
    obs_t oin;
    if (i == 0) begin : g_first
      assign bin = rot_init(bt3_q);
      assign lin = rot_init(lt3_q);
      assign oin = obs3_q;
    end else begin : g_next
      assign bin = brot_q[i-1];
      assign lin = lrot_q[i-1];
      assign oin = cobs_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      brot_q[i] <= rot_step(bin, i);
      lrot_q[i] <= rot_step(lin, i);
      cobs_q[i] <= oin;
    end
  end

  // Sign fix
  rot_t                   bfin, lfin;
  logic signed [XY_W-1:0] cb_q, sb_q, cl_q;
  obs_t                   obsk_q;

  assign bfin = brot_q[CORDIC_STEPS-1];
  assign lfin = lrot_q[CORDIC_STEPS-1];

  always_ff @(posedge clk_i) begin
    cb_q   <= bfin.neg ? -bfin.x : bfin.x;
    sb_q   <= bfin.neg ? -bfin.y : bfin.y;
    cl_q   <= lfin.neg ? -lfin.x : lfin.x;
    obsk_q <= cobs_q[CORDIC_STEPS-1];
  end

  // P1: products
  logic signed [DIST_W:0]   dist_s;
  logic signed [CS_W-1:0]   sb22, cl22;
  logic signed [PLAT_W-1:0] plat1_q;
  logic signed [PNUM_W-1:0] pnum1_q;
  logic [DEN_W-1:0]         den1_q;
  logic                     tiny1_q;
  obs_t                     obsp1_q;

  assign dist_s = $signed({1'b0, obsk_q.rng});
  assign sb22   = CS_W'(sb_q >>> 8);
  assign cl22   = CS_W'(cl_q >>> 8);

  always_ff @(posedge clk_i) begin
    plat1_q <= PLAT_W'(dist_s) * PLAT_W'(cb_q);
    pnum1_q <= PNUM_W'(dist_s) * PNUM_W'(sb22);
    den1_q  <= DEN_W'(cl22) * DEN_W'(60);
    tiny1_q <= cl22 < $signed(CS_W'(TINY_COS_Q22));
    obsp1_q <= obsk_q;
  end

  // P2: latitude reciprocal product, longitude dividend
  logic                     latneg;
  logic [PLAT_W-1:0]        platmag;
  logic [PLAT_W-1:0]        platrnd;
  logic [VLAT_W-1:0]        vlat;
  logic [VLAT_W+REC_W-1:0]  vm;
  logic                     nneg;
  logic [PNUM_W-1:0]        nmag;
  logic [REM_W-1:0]         ndiv;
  logic [VLAT_W-1:0]        vlat2_q;
  logic [QLAT_W-1:0]        q0lat2_q;
  logic                     latneg2_q;
  logic [REM_W-1:0]         n2_q;
  logic [DEN_W-1:0]         den2_q;
  logic                     ovf2_q, tiny2_q, nneg2_q, nzero2_q;
  obs_t                     obsp2_q;

  always_comb begin
    latneg  = plat1_q[PLAT_W-1];
    platmag = latneg ? PLAT_W'(-plat1_q) : PLAT_W'(plat1_q);
    platrnd = platmag + PLAT_W'(30 << LAT_SH);
    vlat    = VLAT_W'(platrnd >> LAT_SH);
    vm      = (VLAT_W+REC_W)'(vlat) * (VLAT_W+REC_W)'(RECIP60);
    nneg    = pnum1_q[PNUM_W-1];
    nmag    = nneg ? PNUM_W'(-pnum1_q) : PNUM_W'(pnum1_q);
    ndiv    = (REM_W'(nmag) << LNG_SH) + REM_W'(den1_q >> 1);
  end

  always_ff @(posedge clk_i) begin
    vlat2_q   <= vlat;
    q0lat2_q  <= vm[VLAT_W+REC_W-1:32];
    latneg2_q <= latneg;
    n2_q      <= ndiv;
    den2_q    <= den1_q;
    ovf2_q    <= ndiv >= (REM_W'(den1_q) << DIV_BITS);
    tiny2_q   <= tiny1_q;
    nneg2_q   <= nneg;
    nzero2_q  <= (pnum1_q == '0);
    obsp2_q   <= obsp1_q;
  end

  // Latitude finish, enters the divider side band
  logic [VLAT_W-1:0]        rlat_full;
  logic [6:0]               rlat;
  logic [QLAT_W-1:0]        qlat;
  logic signed [QLAT_W:0]   dlat;
  logic signed [LAT_W+1:0]  tlat_sum;
  dside_t                   side0;

  always_comb begin
    rlat_full = vlat2_q - VLAT_W'(q0lat2_q) * VLAT_W'(60);
    rlat      = rlat_full[6:0];
    qlat      = (rlat >= 7'd60) ? q0lat2_q + QLAT_W'(1) : q0lat2_q;
    dlat      = latneg2_q ? -$signed({1'b0, qlat}) : $signed({1'b0, qlat});
    tlat_sum  = (LAT_W+2)'(obsp2_q.olat) + (LAT_W+2)'(dlat);
    side0     = '0;
    if (tlat_sum > (LAT_W+2)'(LAT_LIM)) begin
      side0.tlat    = LAT_LIM;
      side0.lat_sat = 1'b1;
    end else if (tlat_sum < -(LAT_W+2)'(LAT_LIM)) begin
      side0.tlat    = -LAT_LIM;
      side0.lat_sat = 1'b1;
    end else begin
      side0.tlat    = LAT_W'(tlat_sum);
      side0.lat_sat = 1'b0;
    end
    side0.olng  = obsp2_q.olng;
    side0.den   = den2_q;
    side0.ovf   = ovf2_q;
    side0.tiny  = tiny2_q;
    side0.nneg  = nneg2_q;
    side0.nzero = nzero2_q;
  end

  // Longitude divider: one quotient bit per stage, most significant first
  logic [REM_W-1:0]    rem_q  [DIV_BITS];
  logic [DIV_BITS-1:0] quo_q  [DIV_BITS];
  dside_t              dside_q[DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int K = DIV_BITS - 1 - j;
    logic [REM_W-1:0]    rin;
    logic [DIV_BITS-1:0] qin;
    dside_t              sin;
    logic [REM_W-1:0]    dsh;
    if (j == 0) begin : g_first
      assign rin = n2_q;
      assign qin = '0;
      assign sin = side0;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign qin = quo_q[j-1];
      assign sin = dside_q[j-1];
    end
    assign dsh = REM_W'(sin.den) << K;
    always_ff @(posedge clk_i) begin
      if (rin >= dsh) begin
        rem_q[j]    <= rin - dsh;
        quo_q[j]    <= qin | (DIV_BITS'(1) << K);
      end else begin
        rem_q[j]    <= rin;
        quo_q[j]    <= qin;
      end
      dside_q[j] <= sin;
    end
  end

  // F: longitude sum and saturation
  dside_t                    dl;
  logic [DIV_BITS:0]         qlng;
  logic signed [DIV_BITS+1:0] dlng;
  logic signed [LNG_W+2:0]   lng_sum;
  logic signed [LNG_W-1:0]   tlng;
  logic                      lng_sat;
  logic signed [LAT_W-1:0]   tlatf_q;
  logic signed [LNG_W-1:0]   tlngf_q;
  logic                      satf_q;

  always_comb begin
    dl      = dside_q[DIV_BITS-1];
    qlng    = dl.ovf ? ((DIV_BITS+1)'(1) << DIV_BITS) : {1'b0, quo_q[DIV_BITS-1]};
    dlng    = dl.nneg ? -$signed({1'b0, qlng}) : $signed({1'b0, qlng});
    lng_sum = (LNG_W+3)'(dl.olng) + (LNG_W+3)'(dlng);
    if (dl.tiny) begin
      lng_sat = 1'b1;
      if (!dl.nzero) begin
        tlng = dl.nneg ? -LNG_LIM : LNG_LIM;
      end else if (dl.olng > LNG_LIM) begin
        tlng = LNG_LIM;
      end else if (dl.olng < -LNG_LIM) begin
        tlng = -LNG_LIM;
      end else begin
        tlng = dl.olng;
      end
    end else if (lng_sum > (LNG_W+3)'(LNG_LIM)) begin
      tlng    = LNG_LIM;
      lng_sat = 1'b1;
    end else if (lng_sum < -(LNG_W+3)'(LNG_LIM)) begin
      tlng    = -LNG_LIM;
      lng_sat = 1'b1;
    end else begin
      tlng    = LNG_W'(lng_sum);
      lng_sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    tlatf_q <= dl.tlat;
    tlngf_q <= tlng;
    satf_q  <= dl.lat_sat | lng_sat;
  end

  // O: geofence and output registers
  logic signed [LAT_W-1:0] tlat_out_q;
  logic signed [LNG_W-1:0] tlng_out_q;
  logic                    inreg_q, oor_q;

  always_ff @(posedge clk_i) begin
    tlat_out_q <= tlatf_q;
    tlng_out_q <= tlngf_q;
    oor_q      <= satf_q;
    inreg_q    <= (tlatf_q >= lat_min_q) && (tlatf_q <= lat_max_q) &&
                  (tlngf_q >= lng_min_q) && (tlngf_q <= lng_max_q);
  end

  assign target_lat_o   = tlat_out_q;
  assign target_lng_o   = tlng_out_q;
  assign in_region_o    = inreg_q;
  assign out_of_range_o = oor_q;

endmodule

// File: rtl/rbpg_checker.sv
// Port-level checker for the range/bearing position core, bound to the top.
// Depends on rbpg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbpg_checker import rbpg_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    done_o,
  input logic signed [LAT_W-1:0] target_lat_o,
  input logic signed [LNG_W-1:0] target_lng_o
);

  logic taken, lat_ok, lng_ok;

  assign taken  = start_i && !busy_o;
  assign lat_ok = target_lat_o <= LAT_LIM && target_lat_o >= -LAT_LIM;
  assign lng_ok = target_lng_o <= LNG_LIM && target_lng_o >= -LNG_LIM;

  `RBPG_ASSERT_DELAY(a_result_follows, clk_i, rst_ni, taken, LATENCY, done_o)
  `RBPG_ASSERT_IMPLY(a_result_has_source, clk_i, rst_ni, done_o, $past(taken, LATENCY))
  `RBPG_ASSERT_IMPLY(a_lat_bounded, clk_i, rst_ni, done_o, lat_ok)
  `RBPG_ASSERT_IMPLY(a_lng_bounded, clk_i, rst_ni, done_o, lng_ok)

endmodule

bind range_bearing_position_geofence_core rbpg_checker u_rbpg_checker (.*);

// File: verif/tb_top.sv
// Self-checking testbench for range_bearing_position_geofence_core.
// Predicts target position, geofence and saturation flags per transaction and
// compares every done_o strobe in order; depends on rbpg_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import rbpg_pkg::*;

  localparam int RUN_LIMIT = 200000;

  typedef struct {
    logic signed [LAT_W-1:0] lat;
    logic signed [LNG_W-1:0] lng;
    logic [BRG_W-1:0]        brg;
    logic [DIST_W-1:0]       rng;
  } sighting_t;

  typedef struct {
    logic signed [LAT_W-1:0] tlat;
    logic signed [LNG_W-1:0] tlng;
    logic                    in_fence;
    logic                    sat;
  } fix_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic signed [LAT_W-1:0] observer_lat_i = '0;
  logic signed [LNG_W-1:0] observer_lng_i = '0;
  logic [BRG_W-1:0]        bearing_i = '0;
  logic [DIST_W-1:0]       distance_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_W-1:0]        cfg_data_i = '0;
  logic                    busy_o, done_o, in_region_o, out_of_range_o;
  logic signed [LAT_W-1:0] target_lat_o;
  logic signed [LNG_W-1:0] target_lng_o;

  sighting_t sighting_q[$];
  fix_t      fix_q[$];
  sighting_t cur_sighting;
  longint    fence_lat_min, fence_lat_max, fence_lng_min, fence_lng_max;
  int        idle_pct = 0;
  int        n_sent = 0, n_checked = 0, n_inside = 0, n_sat = 0, n_errors = 0;
  int        cycle_cnt = 0;

  range_bearing_position_geofence_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint div_near(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint clip(longint v, longint lim, inout bit sat);
    if (v > lim) begin
      sat = 1'b1;
      return lim;
    end
    if (v < -lim) begin
      sat = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  function automatic void rotate(bit [31:0] ang, output longint c, output longint s);
    bit     flip;
    longint x, y, z, nx;
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang + 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic fix_t predict_fix(sighting_t t);
    longint    olat, olng, brg, rng, cb, sb, cl, sl, tlat, tlng, num, cl22;
    longint    lat_lim, lng_lim;
    bit [31:0] bturns, lturns;
    bit        sat;
    fix_t      r;
    lat_lim = longint'(90) <<< COORD_FRAC_BITS;
    lng_lim = longint'(180) <<< COORD_FRAC_BITS;
    olat = t.lat;
    olng = t.lng;
    brg  = longint'(t.brg);
    rng  = longint'(t.rng);
    sat  = 1'b0;
    bturns = 32'((brg * 65536 + 180) / 360);
    rotate(bturns, cb, sb);
    lturns = 32'(div_near(olat * (longint'(1) <<< (32 - COORD_FRAC_BITS)), 360));
    rotate(lturns, cl, sl);
    tlat = olat + div_near(rng * cb, longint'(60) <<< (38 - COORD_FRAC_BITS));
    tlat = clip(tlat, lat_lim, sat);
    num  = rng * (sb >>> 8) * (longint'(1) <<< (COORD_FRAC_BITS - 8));
    cl22 = cl >>> 8;
    if (cl22 < TINY_COS_Q22) begin
      sat = 1'b1;
      if (num == 0) tlng = clip(olng, lng_lim, sat);
      else tlng = (num > 0) ? lng_lim : -lng_lim;
    end else begin
      tlng = clip(olng + div_near(num, 60 * cl22), lng_lim, sat);
    end
    r.tlat     = LAT_W'(tlat);
    r.tlng     = LNG_W'(tlng);
    r.in_fence = tlat >= fence_lat_min && tlat <= fence_lat_max &&
                 tlng >= fence_lng_min && tlng <= fence_lng_max;
    r.sat      = sat;
    return r;
  endfunction

  // driver: hand out pending sightings, record the expected fix on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        fix_q.push_back(predict_fix(cur_sighting));
        n_sent++;
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (sighting_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur_sighting   = sighting_q.pop_front();
        start_i        <= 1'b1;
        observer_lat_i <= cur_sighting.lat;
        observer_lng_i <= cur_sighting.lng;
        bearing_i      <= cur_sighting.brg;
        distance_i     <= cur_sighting.rng;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: check every result transaction against the oldest expected fix
  always @(posedge clk_i) begin
    fix_t e;
    if (rst_ni && done_o) begin
      if (fix_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result lat=%0d lng=%0d", $time, target_lat_o, target_lng_o);
      end else begin
        e = fix_q.pop_front();
        n_checked++;
        n_inside += e.in_fence;
        n_sat += e.sat;
        if (target_lat_o !== e.tlat || target_lng_o !== e.tlng ||
            in_region_o !== e.in_fence || out_of_range_o !== e.sat) begin
          n_errors++;
          $display("%0t: mismatch expected lat=%0d lng=%0d in=%0b sat=%0b actual lat=%0d lng=%0d in=%0b sat=%0b",
                   $time, e.tlat, e.tlng, e.in_fence, e.sat,
                   target_lat_o, target_lng_o, in_region_o, out_of_range_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_sighting(longint lat, longint lng, longint brg, longint rng);
    sighting_t t;
    t.lat = LAT_W'(lat);
    t.lng = LNG_W'(lng);
    t.brg = BRG_W'(brg);
    t.rng = DIST_W'(rng);
    sighting_q.push_back(t);
  endtask

  task automatic add_random(int count);
    longint lat, lng, brg, rng;
    for (int i = 0; i < count; i++) begin
      brg  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 33554431)
                                          : $urandom_range(0, 23592959);
      rng  = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
        6: begin
          lat  = fence_lat_min - 2097152 + longint'($urandom_range(0, 6291456));
          lng  = fence_lng_min - 2097152 + longint'($urandom_range(0, 6291456));
          rng  = $urandom_range(0, 2047);
        end
        7: begin
          lat = 94266982 + longint'($urandom_range(0, 209715));
          if ($urandom_range(0, 1)) lat = -lat;
          lng = longint'($urandom_range(0, 377487360)) - 188743680;
        end
        8: begin
          lat = longint'($urandom) & 32'hFFF_FFFF;
          lng = longint'($urandom) & 32'h1FFF_FFFF;
        end
        9: begin
          lat = longint'($urandom_range(0, 125829120)) - 62914560;
          lng = 186646528 + longint'($urandom_range(0, 2097152));
          if ($urandom_range(0, 1)) lng = -lng;
        end
        default: begin
          lat = longint'($urandom_range(0, 167772160)) - 83886080;
          lng = longint'($urandom_range(0, 375390208)) - 187695104;
        end
      endcase
      add_sighting(lat, lng, brg, rng);
    end
  endtask

  task automatic write_fence(logic [CFG_IDX_W-1:0] idx, longint val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
    case (idx)
      CFG_LAT_MIN: fence_lat_min = longint'($signed(LAT_W'(val)));
      CFG_LAT_MAX: fence_lat_max = longint'($signed(LAT_W'(val)));
      CFG_LNG_MIN: fence_lng_min = longint'($signed(LNG_W'(val)));
      default:     fence_lng_max = longint'($signed(LNG_W'(val)));
    endcase
  endtask

  task automatic set_fence(longint lat0, longint lat1, longint lng0, longint lng1);
    write_fence(CFG_LAT_MIN, lat0);
    write_fence(CFG_LAT_MAX, lat1);
    write_fence(CFG_LNG_MIN, lng0);
    write_fence(CFG_LNG_MAX, lng1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (sighting_q.size() > 0 || fix_q.size() > 0 || start_i) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    fence_lat_min = LAT_MIN_RST;
    fence_lat_max = LAT_MAX_RST;
    fence_lng_min = LNG_MIN_RST;
    fence_lng_max = LNG_MAX_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, cardinal bearings, poles, wrap, default box
    add_sighting(0, 0, 0, 0);
    add_sighting(54788096, -5242880, 0, 0);
    add_sighting(54788096, -5242880, 2949120, 300);
    add_sighting(94371840, 0, 0, 65535);
    add_sighting(-94371840, 0, 11796480, 65535);
    add_sighting(134217727, 268435455, 23592959, 65535);
    add_sighting(-134217728, -268435456, 0, 1);
    add_sighting(94319411, 1000, 5898240, 1000);
    add_sighting(-94319411, 200000000, 5898240, 0);
    add_sighting(94371840, -200000000, 17694720, 500);
    add_sighting(0, 188743680, 5898240, 65535);
    add_sighting(0, -188743680, 17694720, 65535);
    add_sighting(10485760, 0, 23592960, 12345);
    add_sighting(-10485760, 0, 33554431, 40000);
    add_sighting(-62914560, 1048576, 5898240, 30000);
    add_sighting(-62914560, 1048576, 11796480, 30000);
    add_sighting(-62914560, 1048576, 17694720, 30000);
    add_sighting(31457280, -31457280, 23592959, 65535);
    add_random(210);
    drain();

    set_fence(-134217728, 134217727, -268435456, 268435455);
    idle_pct = 49;
    add_random(230);
    drain();

    set_fence(94371840, -94371840, 188743680, -188743680);
    idle_pct = 29;
    add_random(220);
    drain();

    set_fence(-20971520, 41943040, -52428800, 104857600);
    idle_pct = 0;
    add_random(120);
    idle_pct = 49;
    add_random(100);
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d sightings, checked %0d fixes over four geofence settings",
             n_sent, n_checked);
    $display("%0d fixes inside the fence, %0d saturated or near a pole", n_inside, n_sat);
    if (n_errors == 0 && fix_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rbpg_pkg.sv
rtl/range_bearing_position_geofence_core.sv
rtl/rbpg_checker.sv
verif/tb_top.sv
